>>> hw/rtl/bpl_pkg.sv
// Shared types and constants for the bounded positional list.
// Used by bpl_engine and bounded_positional_list; depends on nothing.
package bpl_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int OP_W          = 4;
    localparam int POS_W         = 7;
    localparam int VAL_W         = 32;

    // request codes
    localparam logic [OP_W-1:0] OP_INS_AT    = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd2;
    localparam logic [OP_W-1:0] OP_REM_AT    = 4'd3;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 4'd4;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 4'd5;
    localparam logic [OP_W-1:0] OP_REPLACE   = 4'd6;
    localparam logic [OP_W-1:0] OP_READ      = 4'd7;
    localparam logic [OP_W-1:0] OP_FIND      = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_size;
        logic                    is_empty;
        logic                    is_full;
    } t_out_item;

endpackage

>>> hw/rtl/bounded_positional_list.sv
// Bounded positional list: ordered list of up to LIST_DEPTH signed words.
// Replace writes the entry RAM at accept; read waits for the registered RAM data; insert
// and remove first move the entries behind the position; find scans the entries until a
// match or the end of the list. A finished result is held while the output stalls.
// Throughput: one item at a time; the next item is taken the cycle after hand-over.
// Reset (i_rst_n low, synchronous): list empty, no result pending; RAM not cleared.
module bounded_positional_list #(
    parameter int LIST_DEPTH = bpl_pkg::DEFAULT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpl_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(LIST_DEPTH);

    logic                      eng_idle;
    logic                      eng_done;
    logic                      eng_ack;
    logic                      in_fire;
    bpl_pkg::t_out_item        eng_result;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [bpl_pkg::VAL_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [bpl_pkg::VAL_W-1:0] ram_rdata;

    logic                      r_out_valid;
    bpl_pkg::t_out_item        r_out_item;

    // Take a new item whenever the sequencer is idle; a finished result may
    // still be waiting in the output register meanwhile.
    assign o_in_ready = eng_idle;
    assign in_fire    = i_in_valid && eng_idle;

    // Hand the result over once the output register is free or being drained.
    assign eng_ack = eng_done && (!r_out_valid || i_out_ready);

    bpl_engine #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_fire),
        .i_cmd       (i_in_item),
        .i_ack       (eng_ack),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_result    (eng_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Entry store: one word per list position.
    bpl_ram #(
        .WIDTH (bpl_pkg::VAL_W),
        .DEPTH (LIST_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: load on hand-over, drop once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ack) begin
            r_out_item <= eng_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/bpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bpl_engine.sv
// Sequencer of the bounded positional list: decodes a request, walks the
// entry RAM with one shared pointer/tag unit, and holds the result.
// Depends on bpl_pkg; drives the ports of one bpl_ram.
module bpl_engine #(
    parameter int LIST_DEPTH = bpl_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  bpl_pkg::t_in_item             i_cmd,
    input  logic                          i_ack,
    output logic                          o_idle,
    output logic                          o_done,
    output bpl_pkg::t_out_item            o_result,
    output logic                          o_ram_we,
    output logic [$clog2(LIST_DEPTH)-1:0] o_ram_waddr,
    output logic [bpl_pkg::VAL_W-1:0]     o_ram_wdata,
    output logic [$clog2(LIST_DEPTH)-1:0] o_ram_raddr,
    input  logic [bpl_pkg::VAL_W-1:0]     i_ram_rdata
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (CW > bpl_pkg::POS_W) ? CW : bpl_pkg::POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_rd_on, n_rd_on;
    logic                      r_pend,  n_pend;
    logic [AW-1:0]             r_ptr,   n_ptr;
    logic [AW-1:0]             r_stop,  n_stop;
    logic [AW-1:0]             r_tag,   n_tag;
    logic                      r_up,    n_up;
    logic                      r_is_ins, n_is_ins;
    logic [PW-1:0]             r_pos,   n_pos;
    logic [bpl_pkg::VAL_W-1:0] r_val,   n_val;
    logic                      r_ok,    n_ok;
    logic [bpl_pkg::VAL_W-1:0] r_rd_val, n_rd_val;
    logic [PW-1:0]             r_fpos,  n_fpos;

    logic [PW-1:0] c_ext;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] p_sel;
    logic [PW-1:0] p_next;
    logic [PW-1:0] c_last;
    logic          full;
    logic          empty;
    logic          hit;

    assign c_ext   = PW'(r_count);
    assign pos_ext = PW'(i_cmd.position);
    assign c_last  = c_ext - PW'(1);
    assign full    = (r_count == CW'(LIST_DEPTH));
    assign empty   = (r_count == '0);
    assign hit     = r_pend && (i_ram_rdata == r_val);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_on  = r_rd_on;
        n_pend   = r_pend;
        n_ptr    = r_ptr;
        n_stop   = r_stop;
        n_tag    = r_tag;
        n_up     = r_up;
        n_is_ins = r_is_ins;
        n_pos    = r_pos;
        n_val    = r_val;
        n_ok     = r_ok;
        n_rd_val = r_rd_val;
        n_fpos   = r_fpos;
        p_sel    = '0;
        p_next   = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_cmd.item_value;
                    n_ok     = 1'b0;
                    n_rd_val = '0;
                    n_fpos   = '0;
                    n_rd_on  = 1'b0;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    case (i_cmd.op)
                        bpl_pkg::OP_INS_AT, bpl_pkg::OP_INS_FRONT,
                        bpl_pkg::OP_INS_BACK: begin
                            if (i_cmd.op == bpl_pkg::OP_INS_FRONT) begin
                                p_sel = '0;
                            end else if (i_cmd.op == bpl_pkg::OP_INS_BACK) begin
                                p_sel = c_ext;
                            end else begin
                                p_sel = pos_ext;
                            end
                            if (!full && p_sel <= c_ext) begin
                                n_ok     = 1'b1;
                                n_pos    = p_sel;
                                n_is_ins = 1'b1;
                                n_state  = S_MOVE;
                                // open a gap: copy entries upward, top first
                                if (p_sel < c_ext) begin
                                    n_rd_on = 1'b1;
                                    n_up    = 1'b1;
                                    n_ptr   = c_last[AW-1:0];
                                    n_stop  = p_sel[AW-1:0];
                                end
                            end
                        end
                        bpl_pkg::OP_REM_AT, bpl_pkg::OP_REM_FRONT,
                        bpl_pkg::OP_REM_BACK: begin
                            if (i_cmd.op == bpl_pkg::OP_REM_FRONT) begin
                                p_sel = '0;
                            end else if (i_cmd.op == bpl_pkg::OP_REM_BACK) begin
                                p_sel = empty ? '0 : c_last;
                            end else begin
                                p_sel = pos_ext;
                            end
                            p_next = p_sel + PW'(1);
                            if (!empty && p_sel < c_ext) begin
                                n_ok     = 1'b1;
                                n_is_ins = 1'b0;
                                n_state  = S_MOVE;
                                // close the gap: copy entries downward, bottom first
                                if (p_next < c_ext) begin
                                    n_rd_on = 1'b1;
                                    n_up    = 1'b0;
                                    n_ptr   = p_next[AW-1:0];
                                    n_stop  = c_last[AW-1:0];
                                end
                            end
                        end
                        bpl_pkg::OP_REPLACE: begin
                            if (pos_ext < c_ext) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = pos_ext[AW-1:0];
                                o_ram_wdata = i_cmd.item_value;
                                n_ok        = 1'b1;
                            end
                        end
                        bpl_pkg::OP_READ: begin
                            if (pos_ext < c_ext) begin
                                o_ram_raddr = pos_ext[AW-1:0];
                                n_ok        = 1'b1;
                                n_state     = S_READ;
                            end else if (!empty) begin
                                o_ram_raddr = c_last[AW-1:0];
                                n_state     = S_READ;
                            end
                        end
                        bpl_pkg::OP_FIND: begin
                            n_fpos = c_ext;
                            if (!empty) begin
                                n_rd_on = 1'b1;
                                n_up    = 1'b0;
                                n_ptr   = '0;
                                n_stop  = c_last[AW-1:0];
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_tag;
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_rd_on) begin
                    o_ram_raddr = r_ptr;
                    n_pend      = 1'b1;
                    n_tag       = r_up ? r_ptr + AW'(1) : r_ptr - AW'(1);
                    if (r_ptr == r_stop) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_up ? r_ptr - AW'(1) : r_ptr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_rd_on && !r_pend) begin
                    if (r_is_ins) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = r_pos[AW-1:0];
                        o_ram_wdata = r_val;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_rd_val = i_ram_rdata;
                n_state  = S_DONE;
            end
            S_FIND: begin
                if (hit) begin
                    n_ok    = 1'b1;
                    n_fpos  = PW'(r_tag);
                    n_rd_on = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    if (r_rd_on) begin
                        o_ram_raddr = r_ptr;
                        n_pend      = 1'b1;
                        n_tag       = r_ptr;
                        if (r_ptr == r_stop) begin
                            n_rd_on = 1'b0;
                        end else begin
                            n_ptr = r_ptr + AW'(1);
                        end
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (!r_rd_on && !r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_on <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_on <= n_rd_on;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_stop   <= n_stop;
        r_tag    <= n_tag;
        r_up     <= n_up;
        r_is_ins <= n_is_ins;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_rd_val <= n_rd_val;
        r_fpos   <= n_fpos;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.ok             = r_ok;
    assign o_result.read_value     = r_rd_val;
    assign o_result.found_position = r_fpos[bpl_pkg::POS_W-1:0];
    assign o_result.list_size      = c_ext[bpl_pkg::POS_W-1:0];
    assign o_result.is_empty       = empty;
    assign o_result.is_full        = full;

endmodule
